// ===== hdl/mme_pkg.sv =====
// Shared types, constants and helpers of the matrix multiply engine.
// Used by the top level and the cell; depends on nothing.
package mme_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int IDX_W       = 3;   // row/column index width
  localparam int ACC_W       = 36;  // accumulator width
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 32;

  // action codes
  localparam logic [1:0] ACT_WR_A    = 2'd0;
  localparam logic [1:0] ACT_WR_B    = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIM_ERR = 2'd1;
  localparam logic [1:0] ST_IDX_ERR = 2'd2;

  // register indexes
  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  // word passed from cell to cell along the chain
  typedef struct packed {
    logic                     v;
    logic signed [ELEM_W-1:0] a;
    logic [IDX_W-1:0]         k;
    logic                     clr;  // first term of a dot product
    logic                     fin;  // last term of a dot product
  } pass_t;

  // clamp accumulator to signed 32 bits
  function automatic logic signed [PROD_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-PROD_W:0] top;
    begin
      top = x[ACC_W-1:PROD_W-1];
      if (top == '0 || top == '1) begin
        sat32 = x[PROD_W-1:0];
      end else if (x[ACC_W-1]) begin
        sat32 = {1'b1, {(PROD_W-1){1'b0}}};
      end else begin
        sat32 = {1'b0, {(PROD_W-1){1'b1}}};
      end
    end
  endfunction

endpackage

// ===== hdl/matrix_multiply_engine.sv =====
// Matrix multiply engine top level: APB registers, A store, cell chain, sequencer.
// A load's word is registered and appears in the cycle after acceptance. A compute
// feeds, per row, a_cols terms, drains the cell chain, then gives b_cols output
// words; items are taken one at a time, a load per cycle unless the output stalls.
// Reset (async, active low) sets all dimension registers to MAX_DIM; stores are
// undefined until written.
module matrix_multiply_engine #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        action_i,
  input  logic [mme_pkg::IDX_W-1:0]         row_index_i,
  input  logic [mme_pkg::IDX_W-1:0]         col_index_i,
  input  logic signed [mme_pkg::ELEM_W-1:0] element_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic [mme_pkg::IDX_W-1:0]         out_row_o,
  output logic [mme_pkg::IDX_W-1:0]         out_col_o,
  output logic signed [mme_pkg::PROD_W-1:0] product_value_o,
  output logic                              last_result_o
);
  import mme_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DRAIN = MAX_DIM + 3;
  localparam int DW    = $clog2(DRAIN + 1);

  typedef enum logic [1:0] {S_IDLE, S_FEED, S_DRAIN, S_EMIT} state_e;

  // configuration registers
  logic [3:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= 4'(MAX_DIM);
      a_cols_q <= 4'(MAX_DIM);
      b_rows_q <= 4'(MAX_DIM);
      b_cols_q <= 4'(MAX_DIM);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_A_ROWS: a_rows_q <= pwdata[3:0];
        REG_A_COLS: a_cols_q <= pwdata[3:0];
        REG_B_ROWS: b_rows_q <= pwdata[3:0];
        REG_B_COLS: b_cols_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_A_ROWS: prdata = {28'd0, a_rows_q};
      REG_A_COLS: prdata = {28'd0, a_cols_q};
      REG_B_ROWS: prdata = {28'd0, b_rows_q};
      REG_B_COLS: prdata = {28'd0, b_cols_q};
      default:    prdata = '0;
    endcase
  end

  // input decode
  state_e             state_q;
  logic               out_v_q;
  logic               out_free, in_acc, idx_bad, dim_bad;
  logic [3:0]         nr, nc;

  assign out_free   = !out_v_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign nr = (action_i == ACT_WR_A) ? a_rows_q : b_rows_q;
  assign nc = (action_i == ACT_WR_A) ? a_cols_q : b_cols_q;
  assign idx_bad = ({1'b0, row_index_i} >= nr) || ({1'b0, col_index_i} >= nc) ||
                   ({1'b0, row_index_i} >= 4'(MAX_DIM)) ||
                   ({1'b0, col_index_i} >= 4'(MAX_DIM));
  assign dim_bad = (a_rows_q == 4'd0) || (a_rows_q > 4'(MAX_DIM)) ||
                   (a_cols_q == 4'd0) || (a_cols_q > 4'(MAX_DIM)) ||
                   (b_rows_q == 4'd0) || (b_rows_q > 4'(MAX_DIM)) ||
                   (b_cols_q == 4'd0) || (b_cols_q > 4'(MAX_DIM)) ||
                   (a_cols_q != b_rows_q);

  // A store
  logic              a_we, b_we;
  logic [AW-1:0]     a_waddr, a_raddr;
  logic [ELEM_W-1:0] a_rdata;
  logic [IDX_W-1:0]  i_q, k_q, j_q;

  assign a_we    = in_acc && (action_i == ACT_WR_A) && !idx_bad;
  assign b_we    = in_acc && (action_i == ACT_WR_B) && !idx_bad;
  assign a_waddr = AW'(row_index_i * MAX_DIM + col_index_i);
  assign a_raddr = AW'(i_q * MAX_DIM + k_q);

  mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_store (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (element_value_i),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  // cell chain
  pass_t                    chain [MAX_DIM+1];
  logic signed [PROD_W-1:0] res [MAX_DIM];
  logic                     f_v_q, f_clr_q, f_fin_q;
  logic [IDX_W-1:0]         f_k_q;

  always_comb begin
    chain[0].v   = f_v_q;
    chain[0].a   = a_rdata;
    chain[0].k   = f_k_q;
    chain[0].clr = f_clr_q;
    chain[0].fin = f_fin_q;
  end

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    mme_cell #(.MAX_DIM(MAX_DIM)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .pass_i  (chain[c]),
      .pass_o  (chain[c+1]),
      .bwe_i   (b_we && (col_index_i == IDX_W'(c))),
      .brow_i  (row_index_i),
      .bdata_i (element_value_i),
      .res_o   (res[c])
    );
  end

  // sequencer and output register
  logic [DW-1:0]      d_q;
  logic               k_last, j_last, i_last;
  logic [1:0]         st_q;
  logic [IDX_W-1:0]   row_q, col_q;
  logic [PROD_W-1:0]  val_q;
  logic               last_q;
  logic               out_load;

  assign k_last = ({1'b0, k_q} + 4'd1) == a_cols_q;
  assign j_last = ({1'b0, j_q} + 4'd1) == b_cols_q;
  assign i_last = ({1'b0, i_q} + 4'd1) == a_rows_q;

  // a new output word is loaded this cycle
  assign out_load = ((state_q == S_IDLE) && in_acc &&
                     ((action_i == ACT_WR_A) || (action_i == ACT_WR_B) ||
                      ((action_i == ACT_COMPUTE) && dim_bad))) ||
                    ((state_q == S_EMIT) && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      f_v_q   <= 1'b0;
      f_clr_q <= 1'b0;
      f_fin_q <= 1'b0;
      f_k_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      d_q     <= '0;
      st_q    <= ST_OK;
      row_q   <= '0;
      col_q   <= '0;
      val_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      f_v_q <= (state_q == S_FEED);
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (action_i == ACT_WR_A || action_i == ACT_WR_B) begin
              st_q    <= idx_bad ? ST_IDX_ERR : ST_OK;
              row_q   <= row_index_i;
              col_q   <= col_index_i;
              val_q   <= '0;
              last_q  <= 1'b1;
            end else if (action_i == ACT_COMPUTE) begin
              if (dim_bad) begin
                st_q    <= ST_DIM_ERR;
                row_q   <= '0;
                col_q   <= '0;
                val_q   <= '0;
                last_q  <= 1'b1;
              end else begin
                state_q <= S_FEED;
                i_q     <= '0;
                k_q     <= '0;
              end
            end
          end
        end
        S_FEED: begin
          f_k_q   <= k_q;
          f_clr_q <= (k_q == '0);
          f_fin_q <= k_last;
          k_q     <= k_q + 1'b1;
          if (k_last) begin
            state_q <= S_DRAIN;
            d_q     <= '0;
          end
        end
        S_DRAIN: begin
          d_q <= d_q + 1'b1;
          if (d_q == DW'(DRAIN - 1)) begin
            state_q <= S_EMIT;
            j_q     <= '0;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            st_q    <= ST_OK;
            row_q   <= i_q;
            col_q   <= j_q;
            val_q   <= res[j_q];
            last_q  <= i_last && j_last;
            j_q     <= j_q + 1'b1;
            if (j_last) begin
              if (i_last) begin
                state_q <= S_IDLE;
              end else begin
                state_q <= S_FEED;
                i_q     <= i_q + 1'b1;
                k_q     <= '0;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_v_q;
  assign status_o        = st_q;
  assign out_row_o       = row_q;
  assign out_col_o       = col_q;
  assign product_value_o = val_q;
  assign last_result_o   = last_q;

  // checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_acc) else $error("item taken while busy");
  a_load_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (action_i == ACT_WR_A || action_i == ACT_WR_B)) |=> out_v_q)
    else $error("load gave no word");
  a_emit_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> ({1'b0, j_q} < b_cols_q)) else $error("column overrun");
  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> !f_v_q) else $error("feed active during output");

endmodule

// ===== hdl/mme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/mme_cell.sv =====
// One multiply-accumulate cell: holds one column of B, forwards the A word
// to its right neighbor. Depends on mme_pkg.
module mme_cell #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mme_pkg::pass_t                   pass_i,
  output mme_pkg::pass_t                   pass_o,
  input  logic                             bwe_i,
  input  logic [mme_pkg::IDX_W-1:0]        brow_i,
  input  logic signed [mme_pkg::ELEM_W-1:0] bdata_i,
  output logic signed [mme_pkg::PROD_W-1:0] res_o
);
  import mme_pkg::*;

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic signed [ELEM_W-1:0] b_q [MAX_DIM];
  logic signed [PROD_W-1:0] p_q;
  logic                     m_v_q, m_clr_q, m_fin_q;
  logic signed [ACC_W-1:0]  acc_q, sum;
  logic signed [PROD_W-1:0] res_q;

  // local column of B
  always_ff @(posedge clk_i) begin
    if (bwe_i) begin
      b_q[brow_i[IW-1:0]] <= bdata_i;
    end
  end

  // forward the A word to the neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_o <= '0;
    end else begin
      pass_o <= pass_i;
    end
  end

  // multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q   <= 1'b0;
      m_clr_q <= 1'b0;
      m_fin_q <= 1'b0;
    end else begin
      m_v_q   <= pass_i.v;
      m_clr_q <= pass_i.clr;
      m_fin_q <= pass_i.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= pass_i.a * b_q[pass_i.k[IW-1:0]];
  end

  // accumulate stage
  assign sum = (m_clr_q ? '0 : acc_q) + ACC_W'(p_q);

  always_ff @(posedge clk_i) begin
    if (m_v_q) begin
      acc_q <= sum;
      if (m_fin_q) begin
        res_q <= sat32(sum);
      end
    end
  end

  assign res_o = res_q;

endmodule
